// ===== hdl/trps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package trps_pkg;

   localparam int COORD_W         = 32;
   localparam int STEP_W          = 7;
   localparam int MAX_STEPS       = 64;
   localparam int ROW_STEPS_RESET = 50;
   localparam int NUM_DIMS        = 3;

   // iterative divider: magnitude of a COORD_W+1 bit dividend, several bits a cycle
   localparam int QUO_W         = COORD_W + 1;
   localparam int DIV_BITS      = 4;
   localparam int DIV_CYCLES    = (QUO_W + DIV_BITS - 1) / DIV_BITS;
   localparam int DIV_SH_W      = DIV_BITS * DIV_CYCLES;
   localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

   typedef struct packed {
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic signed [COORD_W-1:0] a_z;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic signed [COORD_W-1:0] b_z;
      logic signed [COORD_W-1:0] c_x;
      logic signed [COORD_W-1:0] c_y;
      logic signed [COORD_W-1:0] c_z;
      logic [STEP_W-1:0]         row_index;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      last_point;
   } rsp_type;

   typedef logic [NUM_DIMS-1:0][COORD_W-1:0] vec_type;
   typedef logic [NUM_DIMS-1:0][QUO_W-1:0]   wide_vec_type;

   typedef struct packed {
      vec_type           a;
      vec_type           b;
      vec_type           c;
      logic [STEP_W-1:0] steps;
      logic [STEP_W-1:0] row;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage
`default_nettype wire

// ===== hdl/trps_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trps_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output      logic              full,
   input  wire trps_pkg::req_type req_data,
   input  wire logic                        csr_we,
   input  wire logic [trps_pkg::STEP_W-1:0] csr_wdata,
   input  wire trps_pkg::qstat_type         q_stat,
   output      logic                        q_push,
   output      trps_pkg::job_type           q_job
);
   import trps_pkg::*;

   logic [STEP_W-1:0] row_steps_ff, row_steps_in;
   logic [STEP_W-1:0] steps_eff;
   logic [STEP_W-1:0] row_eff;

   always_comb begin
      row_steps_in = csr_we ? csr_wdata : row_steps_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_steps_ff <= STEP_W'(ROW_STEPS_RESET);
      end else begin
         row_steps_ff <= row_steps_in;
      end
   end

   always_comb begin
      if (row_steps_ff == '0) begin
         steps_eff = STEP_W'(1);
      end else if (row_steps_ff > STEP_W'(MAX_STEPS)) begin
         steps_eff = STEP_W'(MAX_STEPS);
      end else begin
         steps_eff = row_steps_ff;
      end
      row_eff = (req_data.row_index > steps_eff) ? steps_eff : req_data.row_index;
   end

   assign full = q_stat.full;

   // drop row zero here: it yields no points
   assign q_push = push && !q_stat.full && (row_eff != '0);

   always_comb begin
      q_job.a     = {req_data.a_z, req_data.a_y, req_data.a_x};
      q_job.b     = {req_data.b_z, req_data.b_y, req_data.b_x};
      q_job.c     = {req_data.c_z, req_data.c_y, req_data.c_x};
      q_job.steps = steps_eff;
      q_job.row   = row_eff;
   end

endmodule
`default_nettype wire

// ===== hdl/trps_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trps_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire trps_pkg::job_type   push_job,
   input  wire logic                pop,
   output      trps_pkg::job_type   head_job,
   output      trps_pkg::qstat_type stat
);
   import trps_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign do_push = push && (count_ff != 2'd2);
   assign do_pop  = pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job   = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);

endmodule
`default_nettype wire

// ===== hdl/trps_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trps_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire trps_pkg::wide_vec_type      dividend,
   input  wire logic [trps_pkg::STEP_W-1:0] divisor,
   output      logic                        done,
   output      trps_pkg::wide_vec_type      quotient
);
   import trps_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [STEP_W-1:0]       divisor_ff;
   logic [NUM_DIMS-1:0]     neg_ff;
   logic [STEP_W-1:0]       rem_ff  [NUM_DIMS];
   logic [DIV_SH_W-1:0]     sh_ff   [NUM_DIMS];
   logic [STEP_W-1:0]       rem_nxt [NUM_DIMS];
   logic [DIV_SH_W-1:0]     sh_nxt  [NUM_DIMS];
   logic [QUO_W-1:0]        mag     [NUM_DIMS];

   // restoring division, DIV_BITS quotient bits per cycle on each lane
   always_comb begin
      logic [STEP_W-1:0]   rem_v;
      logic [DIV_SH_W-1:0] sh_v;
      logic [STEP_W:0]     r_v;
      for (int l = 0; l < NUM_DIMS; l++) begin
         rem_v = rem_ff[l];
         sh_v  = sh_ff[l];
         for (int b = 0; b < DIV_BITS; b++) begin
            r_v  = {rem_v, sh_v[DIV_SH_W-1]};
            sh_v = {sh_v[DIV_SH_W-2:0], 1'b0};
            if (r_v >= {1'b0, divisor_ff}) begin
               rem_v   = STEP_W'(r_v - {1'b0, divisor_ff});
               sh_v[0] = 1'b1;
            end else begin
               rem_v = r_v[STEP_W-1:0];
            end
         end
         rem_nxt[l] = rem_v;
         sh_nxt[l]  = sh_v;
         mag[l]     = dividend[l][QUO_W-1] ? (QUO_W'(0) - dividend[l]) : dividend[l];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         divisor_ff <= divisor;
         for (int l = 0; l < NUM_DIMS; l++) begin
            neg_ff[l] <= dividend[l][QUO_W-1];
            rem_ff[l] <= '0;
            sh_ff[l]  <= DIV_SH_W'(mag[l]);
         end
      end else if (busy_ff) begin
         for (int l = 0; l < NUM_DIMS; l++) begin
            rem_ff[l] <= rem_nxt[l];
            sh_ff[l]  <= sh_nxt[l];
         end
      end
   end

   assign done = done_ff;

   always_comb begin
      for (int l = 0; l < NUM_DIMS; l++) begin
         quotient[l] = neg_ff[l] ? (QUO_W'(0) - sh_ff[l][QUO_W-1:0]) : sh_ff[l][QUO_W-1:0];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/trps_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trps_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire trps_pkg::qstat_type q_stat,
   input  wire trps_pkg::job_type   q_job,
   output      logic                q_pop,
   output      logic                empty,
   input  wire logic                pop,
   output      trps_pkg::rsp_type   rsp_data
);
   import trps_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIVA = 3'd1;
   localparam logic [2:0] ST_DIVC = 3'd2;
   localparam logic [2:0] ST_ENDS = 3'd3;
   localparam logic [2:0] ST_DIFF = 3'd4;
   localparam logic [2:0] ST_DIVL = 3'd5;
   localparam logic [2:0] ST_EMIT = 3'd6;

   logic [2:0]        state_ff, state_in;
   job_type           job_ff;
   wide_vec_type      qa_ff;
   vec_type           l1_ff, l2_ff;
   vec_type           cur_ff, step_ff;
   logic [STEP_W-1:0] left_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;

   logic              div_start, div_done;
   wide_vec_type      div_dividend, quot;
   logic [STEP_W-1:0] div_divisor;
   logic              emit;

   trps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quot)
   );

   assign emit = (state_ff == ST_EMIT) && (!rsp_valid_ff || pop);

   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = job_ff.steps;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               q_pop       = 1'b1;
               div_start   = 1'b1;
               div_divisor = q_job.steps;
               for (int d = 0; d < NUM_DIMS; d++) begin
                  div_dividend[d] = {q_job.a[d][COORD_W-1], q_job.a[d]}
                                  - {q_job.b[d][COORD_W-1], q_job.b[d]};
               end
               state_in = ST_DIVA;
            end
         end
         ST_DIVA: begin
            if (div_done) begin
               div_start = 1'b1;
               for (int d = 0; d < NUM_DIMS; d++) begin
                  div_dividend[d] = {job_ff.c[d][COORD_W-1], job_ff.c[d]}
                                  - {job_ff.b[d][COORD_W-1], job_ff.b[d]};
               end
               state_in = ST_DIVC;
            end
         end
         ST_DIVC: begin
            if (div_done) begin
               state_in = ST_ENDS;
            end
         end
         ST_ENDS: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            div_start   = 1'b1;
            div_divisor = job_ff.row;
            for (int d = 0; d < NUM_DIMS; d++) begin
               div_dividend[d] = {l2_ff[d][COORD_W-1], l2_ff[d]}
                               - {l1_ff[d][COORD_W-1], l1_ff[d]};
            end
            state_in = ST_DIVL;
         end
         ST_DIVL: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit && (left_ff == STEP_W'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_job;
      end
      if ((state_ff == ST_DIVA) && div_done) begin
         qa_ff <= quot;
      end
      // row ends: apex plus edge step times row, wrapped to the coordinate width
      if ((state_ff == ST_DIVC) && div_done) begin
         for (int d = 0; d < NUM_DIMS; d++) begin
            l1_ff[d] <= job_ff.b[d] + COORD_W'(qa_ff[d][COORD_W-1:0] * COORD_W'(job_ff.row));
            l2_ff[d] <= job_ff.b[d] + COORD_W'(quot[d][COORD_W-1:0] * COORD_W'(job_ff.row));
         end
      end
      if ((state_ff == ST_DIVL) && div_done) begin
         cur_ff  <= l1_ff;
         left_ff <= job_ff.row;
         for (int d = 0; d < NUM_DIMS; d++) begin
            step_ff[d] <= quot[d][COORD_W-1:0];
         end
      end
      if (emit) begin
         rsp_ff.point_x    <= cur_ff[0];
         rsp_ff.point_y    <= cur_ff[1];
         rsp_ff.point_z    <= cur_ff[2];
         rsp_ff.last_point <= (left_ff == STEP_W'(1));
         for (int d = 0; d < NUM_DIMS; d++) begin
            cur_ff[d] <= cur_ff[d] + step_ff[d];
         end
         left_ff <= left_ff - STEP_W'(1);
      end
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ===== hdl/triangle_row_point_sampler.sv =====
// A row of j points is queued, popped by the back end and shows its first
// point after three passes of the shared divider (edge steps twice, row
// step once) and the row ends, then one point per cycle while the consumer
// keeps popping. The queue takes new items while a row is in work; rows are
// walked one at a time. A row of zero points is taken and dropped at the front.
// Reset (synchronous, active high) empties both queues and sets row_steps to 50.
`timescale 1ns / 1ps
`default_nettype none
module triangle_row_point_sampler (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   output      logic                        full,
   input  wire trps_pkg::req_type           req_data,
   output      logic                        empty,
   input  wire logic                        pop,
   output      trps_pkg::rsp_type           rsp_data,
   input  wire logic                        csr_we,
   input  wire logic [trps_pkg::STEP_W-1:0] csr_wdata
);
   import trps_pkg::*;

   qstat_type q_stat;
   logic      q_push, q_pop;
   job_type   push_job, head_job;

   trps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   trps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   trps_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .q_job    (head_job),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ===== hdl/trps_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trps_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              full,
   input wire logic              empty,
   input wire logic              pop,
   input wire trps_pkg::rsp_type rsp_data
);

   // nothing to read right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   // a row keeps flowing: popping a point that is not the last refills at once
   a_row_refill: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_data.last_point) |=> !empty)
      else $error("gap inside a row");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("result dropped without transfer");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> $stable(rsp_data))
      else $error("result changed without transfer");

endmodule

bind triangle_row_point_sampler trps_checker u_trps_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);
`default_nettype wire

// ===== tb/sv/triangle_row_point_sampler_test.sv =====
`timescale 1ns / 1ps
module triangle_row_point_sampler_test;
   import trps_pkg::*;

   class point_scoreboard;
      rsp_type          expected_points[$];
      logic [STEP_W-1:0] row_steps_reg;
      int               failures;

      function new();
         row_steps_reg = STEP_W'(ROW_STEPS_RESET);
         failures      = 0;
      endfunction

      function longint wrap_coord(longint v);
         logic signed [COORD_W-1:0] t;
         t = v[COORD_W-1:0];
         return longint'(t);
      endfunction

      // walk one row of the triangle and queue its points
      function void note_request(req_type r);
         longint s, j, k;
         longint av[3], bv[3], cv[3], l1[3], l2[3], pv[3];
         rsp_type p;
         s = row_steps_reg;
         if (s < 1) s = 1;
         if (s > MAX_STEPS) s = MAX_STEPS;
         j = r.row_index;
         if (j > s) j = s;
         if (j == 0) return;
         av[0] = r.a_x; av[1] = r.a_y; av[2] = r.a_z;
         bv[0] = r.b_x; bv[1] = r.b_y; bv[2] = r.b_z;
         cv[0] = r.c_x; cv[1] = r.c_y; cv[2] = r.c_z;
         for (int d = 0; d < 3; d++) begin
            l1[d] = wrap_coord(bv[d] + ((av[d] - bv[d]) / s) * j);
            l2[d] = wrap_coord(bv[d] + ((cv[d] - bv[d]) / s) * j);
         end
         for (k = 0; k < j; k++) begin
            for (int d = 0; d < 3; d++)
               pv[d] = wrap_coord(l1[d] + ((l2[d] - l1[d]) / j) * k);
            p.point_x    = pv[0][COORD_W-1:0];
            p.point_y    = pv[1][COORD_W-1:0];
            p.point_z    = pv[2][COORD_W-1:0];
            p.last_point = (k == j - 1);
            expected_points.insert(expected_points.size(), p);
         end
      endfunction

      function void check_point(rsp_type got);
         rsp_type e;
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected point %h", $time, got);
            failures++;
            return;
         end
         e = expected_points.pop_front();
         if (got.point_x !== e.point_x) begin
            $display("%0t: point_x expected %h actual %h", $time, e.point_x, got.point_x);
            failures++;
         end
         if (got.point_y !== e.point_y) begin
            $display("%0t: point_y expected %h actual %h", $time, e.point_y, got.point_y);
            failures++;
         end
         if (got.point_z !== e.point_z) begin
            $display("%0t: point_z expected %h actual %h", $time, e.point_z, got.point_z);
            failures++;
         end
         if (got.last_point !== e.last_point) begin
            $display("%0t: last_point expected %b actual %b", $time, e.last_point,
                     got.last_point);
            failures++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   req_type           req_data = '0;
   logic              empty;
   logic              pop = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we = 1'b0;
   logic [STEP_W-1:0] csr_wdata = '0;

   point_scoreboard sb;
   logic no_idle = 1'b0;
   int   hold_left = 0;
   int   long_hold_asks = 0;
   int   long_hold_seen = 0;

   triangle_row_point_sampler u_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: check each transfer, then draw the next hold-off
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            sb.check_point(rsp_data);
            hold_left = no_idle ? 0 : $urandom_range(0, 4);
         end
         if (long_hold_asks != long_hold_seen) begin
            long_hold_seen = long_hold_asks;
            hold_left      = 600;
         end
         if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_triangle(logic [STEP_W-1:0] row);
      req_type r;
      r.a_x = pick_coord(); r.a_y = pick_coord(); r.a_z = pick_coord();
      r.b_x = pick_coord(); r.b_y = pick_coord(); r.b_z = pick_coord();
      r.c_x = pick_coord(); r.c_y = pick_coord(); r.c_z = pick_coord();
      r.row_index = row;
      return r;
   endfunction

   task automatic send_triangle(req_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_request(r);
   endtask

   // let the block go idle; a row-zero item may still be in flight
   task automatic drain_points();
      push <= 1'b0;
      while (sb.expected_points.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_row_steps(logic [STEP_W-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.row_steps_reg = v;
   endtask

   task automatic random_rows(int count, int max_row);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_triangle(random_triangle(STEP_W'($urandom_range(0, 127))));
         else
            send_triangle(random_triangle(STEP_W'($urandom_range(0, max_row))));
      end
   endtask

   initial begin
      logic [STEP_W-1:0] steps_list[6];
      req_type r;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at the reset step count
      send_triangle(random_triangle(7'd0));
      send_triangle(random_triangle(7'd1));
      send_triangle(random_triangle(7'd2));
      send_triangle(random_triangle(7'd50));
      send_triangle(random_triangle(7'd127));
      r = '0;
      r.a_x = 32'h7FFF_FFFF; r.a_y = 32'h8000_0000; r.a_z = 32'h7FFF_FFFF;
      r.b_x = 32'h8000_0000; r.b_y = 32'h7FFF_FFFF; r.b_z = 32'h0000_0000;
      r.c_x = 32'h8000_0000; r.c_y = 32'h7FFF_FFFF; r.c_z = 32'hFFFF_FFFF;
      r.row_index = 7'd49;
      send_triangle(r);
      r.a_x = 32'h8000_0000; r.b_x = 32'h7FFF_FFFF; r.c_x = 32'h7FFF_FFFF;
      r.row_index = 7'd64;
      send_triangle(r);
      r = '0;
      r.row_index = 7'd3;
      send_triangle(r);
      r = '1;
      send_triangle(r);

      // fill the block while the result side holds off
      long_hold_asks++;
      random_rows(12, 20);
      drain_points();

      steps_list[0] = 7'd0;
      steps_list[1] = 7'd1;
      steps_list[2] = 7'd64;
      steps_list[3] = 7'd127;
      steps_list[4] = STEP_W'($urandom_range(2, 63));
      steps_list[5] = 7'd50;
      for (int p = 0; p < 6; p++) begin
         write_row_steps(steps_list[p]);
         send_triangle(random_triangle(7'd0));
         send_triangle(random_triangle(7'd1));
         send_triangle(random_triangle(7'd127));
         no_idle <= (p == 2);
         random_rows(50, 16);
         no_idle <= 1'b0;
         drain_points();
      end

      if (sb.failures == 0 && sb.expected_points.size() == 0)
         $display("** triangle_row_point_sampler: PASSED **");
      else
         $display("** triangle_row_point_sampler: FAILED **");
      $finish;
   end

   initial begin
      #20ms;
      $display("** triangle_row_point_sampler: FAILED **");
      $finish;
   end

endmodule
